// ----- rtl/core/filtered_speed_pi_loop_top_assert.svh -----
// assertion macros for the filtered speed pi loop
// used by filtered_speed_pi_loop_top; no other dependencies
`ifndef FILTERED_SPEED_PI_LOOP_TOP_ASSERT_SVH
`define FILTERED_SPEED_PI_LOOP_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define FSPI_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fspi assertion failed");
// condition must never be true outside reset
`define FSPI_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("fspi forbidden condition seen");
`else
`define FSPI_ASSERT(lbl, clk, rstn, prop)
`define FSPI_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- rtl/core/fspi_pkg.sv -----
// package of the filtered speed pi loop: sequencer states, control codes, constants
// no dependencies
`default_nettype none

package fspi_pkg;

    // register map indexes (byte address 4*i)
    localparam logic [1:0] REG_PROP_GAIN      = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN     = 2'd1;
    localparam logic [1:0] REG_FILTER_ALPHA   = 2'd2;
    localparam logic [1:0] REG_INTEGRAL_LIMIT = 2'd3;

    localparam logic [15:0] ALPHA_RESET = 16'd19661;
    localparam logic [15:0] LIMIT_RESET = 16'd3000;

    // datapath widths
    localparam int STATE_W = 40;
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 74;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AE,
        ST_DECAY,
        ST_FILT,
        ST_INTEG,
        ST_P_LO,
        ST_P_HI,
        ST_I_LO,
        ST_I_HI,
        ST_ACC,
        ST_SAT
    } fspi_state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AE,
        MUL_DECAY,
        MUL_P_LO,
        MUL_P_HI,
        MUL_I_LO,
        MUL_I_HI
    } fspi_mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_ADD_SH
    } fspi_acc_op_t;

    typedef struct packed {
        logic          in_ready;
        fspi_mul_sel_t mul_sel;
        fspi_acc_op_t  acc_op;
        logic          load_ae;
        logic          load_filt;
        logic          load_integ;
        logic          load_out;
    } fspi_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/filtered_speed_pi_loop_top.sv -----
// filtered speed pi loop: low-pass on speed error, clamped integral, pi drive output
// depends on fspi_pkg, fspi_mul and filtered_speed_pi_loop_top_assert.svh
//
//  channel   dir   handshake                      payload
//  cfg       in    psel/penable/pwrite, pready=1  paddr[3:2] register, pwdata, prdata
//  s_*       in    s_tvalid / s_tready            s_tdata: speed_measured, speed_target
//  m_*       out   m_tvalid / m_tready            m_tdata: drive_value, m_tuser: clamp flag
//
//  a transaction is one accept step and ten sequencer steps, set by
//  the single shared 40 x 18 multiplier (six products, each through its output register)
//  and the one 74-bit accumulate adder that sums the four gain partial products
//  asynchronous active-low reset clears the filter and integral state and resets the config registers
//  the result waits in an output register; the next input is taken while it waits, and
//  only the final saturation step stalls when the previous result is still not taken
`default_nettype none

`include "filtered_speed_pi_loop_top_assert.svh"

module filtered_speed_pi_loop_top
    import fspi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] speed_measured, [31:16] speed_target
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] drive_value
    output logic      [0:0]  m_tuser    // [0] integral_clamped
);

    // configuration registers
    logic [31:0] prop_gain_reg;
    logic [31:0] integ_gain_reg;
    logic [15:0] filter_alpha_reg;
    logic [15:0] integral_limit_reg;
    logic        cfg_write;

    // sequencer
    fspi_state_t state_reg;
    fspi_state_t state_next;
    fspi_ctrl_t  ctrl;

    // datapath
    logic signed [16:0]          e_reg;
    logic signed [16:0]          e_next;
    logic signed [33:0]          ae_reg;
    logic signed [STATE_W-1:0]   filt_reg;
    logic signed [STATE_W-1:0]   integ_reg;
    logic                        clamp_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    decay_sh;
    logic signed [PROD_W-1:0]    filt_sum;
    logic signed [STATE_W:0]     integ_sum;
    logic signed [STATE_W:0]     bound_pos;
    logic signed [STATE_W:0]     bound_neg;
    logic signed [STATE_W-1:0]   integ_new;
    logic                        clamp_new;
    logic signed [41:0]          acc_hi;
    logic signed [41:0]          drive_hi;
    logic                        round_up;
    logic        [31:0]          drive_sat;

    // output register
    logic        out_valid_reg;
    logic [31:0] drive_reg;
    logic        clamp_out_reg;

    localparam logic signed [41:0] DRIVE_MAX = 42'sd2147483647;
    localparam logic signed [41:0] DRIVE_MIN = -42'sd2147483648;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= '0;
            integ_gain_reg     <= '0;
            filter_alpha_reg   <= ALPHA_RESET;
            integral_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_PROP_GAIN:      prop_gain_reg      <= pwdata;
                REG_INTEG_GAIN:     integ_gain_reg     <= pwdata;
                REG_FILTER_ALPHA:   filter_alpha_reg   <= pwdata[15:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PROP_GAIN:      prdata = prop_gain_reg;
            REG_INTEG_GAIN:     prdata = integ_gain_reg;
            REG_FILTER_ALPHA:   prdata = {16'd0, filter_alpha_reg};
            REG_INTEGRAL_LIMIT: prdata = {16'd0, integral_limit_reg};
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_AE;
            ST_AE:    state_next = ST_DECAY;
            ST_DECAY: state_next = ST_FILT;
            ST_FILT:  state_next = ST_INTEG;
            ST_INTEG: state_next = ST_P_LO;
            ST_P_LO:  state_next = ST_P_HI;
            ST_P_HI:  state_next = ST_I_LO;
            ST_I_LO:  state_next = ST_I_HI;
            ST_I_HI:  state_next = ST_ACC;
            ST_ACC:   state_next = ST_SAT;
            ST_SAT:   if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs per step
    always_comb
    begin
        ctrl = '{in_ready: 1'b0, mul_sel: MUL_NONE, acc_op: ACC_HOLD, load_ae: 1'b0,
                 load_filt: 1'b0, load_integ: 1'b0, load_out: 1'b0};
        unique case (state_reg)
            ST_IDLE:  ctrl.in_ready = 1'b1;
            ST_AE:    ctrl.mul_sel  = MUL_AE;
            ST_DECAY:
            begin
                ctrl.mul_sel = MUL_DECAY;
                ctrl.load_ae = 1'b1;
            end
            ST_FILT:  ctrl.load_filt  = 1'b1;
            ST_INTEG: ctrl.load_integ = 1'b1;
            ST_P_LO:
            begin
                ctrl.mul_sel = MUL_P_LO;
                ctrl.acc_op  = ACC_CLEAR;
            end
            ST_P_HI:
            begin
                ctrl.mul_sel = MUL_P_HI;
                ctrl.acc_op  = ACC_ADD;
            end
            ST_I_LO:
            begin
                ctrl.mul_sel = MUL_I_LO;
                ctrl.acc_op  = ACC_ADD_SH;
            end
            ST_I_HI:
            begin
                ctrl.mul_sel = MUL_I_HI;
                ctrl.acc_op  = ACC_ADD;
            end
            ST_ACC:   ctrl.acc_op   = ACC_ADD_SH;
            ST_SAT:   ctrl.load_out = !out_valid_reg || m_tready;
            default:  ctrl.in_ready = 1'b0;
        endcase
    end

    assign s_tready = ctrl.in_ready;

    // ---------------- shared multiplier ----------------
    // gains are split into a signed upper half and an unsigned lower half
    always_comb
    begin
        unique case (ctrl.mul_sel)
            MUL_AE:
            begin
                mul_a = {{(MUL_A_W-17){e_reg[16]}}, e_reg};
                mul_b = {2'b00, filter_alpha_reg};
            end
            MUL_DECAY:
            begin
                mul_a = filt_reg;
                mul_b = 18'sd65536 - $signed({2'b00, filter_alpha_reg});
            end
            MUL_P_LO:
            begin
                mul_a = filt_reg;
                mul_b = {2'b00, prop_gain_reg[15:0]};
            end
            MUL_P_HI:
            begin
                mul_a = filt_reg;
                mul_b = {{2{prop_gain_reg[31]}}, prop_gain_reg[31:16]};
            end
            MUL_I_LO:
            begin
                mul_a = integ_reg;
                mul_b = {2'b00, integ_gain_reg[15:0]};
            end
            MUL_I_HI:
            begin
                mul_a = integ_reg;
                mul_b = {{2{integ_gain_reg[31]}}, integ_gain_reg[31:16]};
            end
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fspi_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // ---------------- filter and integral ----------------
    assign e_next = $signed({s_tdata[15], s_tdata[15:0]})
                  - $signed({s_tdata[31], s_tdata[31:16]});

    // arithmetic shift gives the floor of the decay term
    assign decay_sh = prod >>> 16;
    assign filt_sum = $signed({{(PROD_W-34){ae_reg[33]}}, ae_reg}) + decay_sh;

    assign integ_sum = $signed({integ_reg[STATE_W-1], integ_reg})
                     + $signed({filt_reg[STATE_W-1], filt_reg});
    assign bound_pos = $signed({9'd0, integral_limit_reg, 16'd0});
    assign bound_neg = -bound_pos;

    // a sum equal to a bound is not a clamp
    always_comb
    begin
        clamp_new = 1'b0;
        integ_new = integ_sum[STATE_W-1:0];
        priority if (integ_sum > bound_pos)
        begin
            integ_new = bound_pos[STATE_W-1:0];
            clamp_new = 1'b1;
        end
        else if (integ_sum < bound_neg)
        begin
            integ_new = bound_neg[STATE_W-1:0];
            clamp_new = 1'b1;
        end
        else
        begin
            integ_new = integ_sum[STATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg  <= '0;
            integ_reg <= '0;
        end
        else
        begin
            if (ctrl.load_filt)
            begin
                filt_reg <= filt_sum[STATE_W-1:0];
            end
            if (ctrl.load_integ)
            begin
                integ_reg <= integ_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            e_reg <= e_next;
        end
        if (ctrl.load_ae)
        begin
            ae_reg <= prod[33:0];
        end
        if (ctrl.load_integ)
        begin
            clamp_reg <= clamp_new;
        end
    end

    // ---------------- drive accumulation ----------------
    // upper-half gain products carry a weight of 2^16
    always_comb
    begin
        unique case (ctrl.acc_op)
            ACC_CLEAR:  acc_next = '0;
            ACC_ADD:    acc_next = acc_reg + $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
            ACC_ADD_SH: acc_next = acc_reg + $signed({prod, 16'd0});
            ACC_HOLD:   acc_next = acc_reg;
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // truncate toward zero, then saturate to 32 bits
    assign acc_hi   = acc_reg[ACC_W-1:32];
    assign round_up = acc_reg[ACC_W-1] && (|acc_reg[31:0]);
    assign drive_hi = acc_hi + $signed({41'd0, round_up});

    always_comb
    begin
        priority if (drive_hi > DRIVE_MAX)
        begin
            drive_sat = DRIVE_MAX[31:0];
        end
        else if (drive_hi < DRIVE_MIN)
        begin
            drive_sat = DRIVE_MIN[31:0];
        end
        else
        begin
            drive_sat = drive_hi[31:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            drive_reg     <= drive_sat;
            clamp_out_reg <= clamp_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = drive_reg;
    assign m_tuser[0] = clamp_out_reg;

    // ---------------- assertions ----------------
    `FSPI_ASSERT(a_accept_starts_seq, clk, rst_n, (s_tvalid && s_tready) |=> (state_reg == ST_AE))
    `FSPI_ASSERT(a_valid_from_sat, clk, rst_n, $rose(out_valid_reg) |-> ($past(state_reg) == ST_SAT))
    `FSPI_ASSERT(a_sat_waits, clk, rst_n, (state_reg == ST_SAT && out_valid_reg && !m_tready) |=> (state_reg == ST_SAT))
    `FSPI_ASSERT(a_clamp_at_bound, clk, rst_n, (state_reg == ST_P_LO && clamp_reg) |-> (integ_reg == bound_pos[STATE_W-1:0] || integ_reg == bound_neg[STATE_W-1:0]))

endmodule

`default_nettype wire

// ----- rtl/core/fspi_mul.sv -----
// shared signed 40 x 18 multiplier with registered product
// uses fspi_pkg for operand widths
`default_nettype none

module fspi_mul
    import fspi_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [MUL_A_W-1:0] op_a,
    input  wire logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]       prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire
